// File: rtl/qrs_pkg.sv
// package for the quadratic root solver: widths, case codes and request/result types
`default_nettype none
package qrs_pkg;

    localparam int COEF_W    = 16;
    localparam int ROOT_W    = 32;
    localparam int COEF_FRAC = 8;
    localparam int ROOT_FRAC = 16;

    typedef enum logic [1:0] {
        CASE_TWO    = 2'd0,
        CASE_DOUBLE = 2'd1,
        CASE_NONE   = 2'd2,
        CASE_DEGEN  = 2'd3
    } t_root_case;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_square;
        logic signed [COEF_W-1:0] coef_linear;
        logic signed [COEF_W-1:0] coef_const;
    } t_req;

    typedef struct packed {
        t_root_case               root_case;
        logic signed [ROOT_W-1:0] root_plus;
        logic signed [ROOT_W-1:0] root_minus;
        logic                     saturated;
    } t_res;

endpackage
`default_nettype wire

// File: rtl/qrs_sqrt_cell.sv
// one cell of the square root chain: resolves one root bit per cycle
`default_nettype none
module qrs_sqrt_cell #(
    parameter int SW     = 25,
    parameter int SIDE_W = 34
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [2*SW-1:0]   i_rad,
    input  wire logic [SW+1:0]     i_rem,
    input  wire logic [SW-1:0]     i_root,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [2*SW-1:0]        o_rad,
    output logic [SW+1:0]          o_rem,
    output logic [SW-1:0]          o_root,
    output logic [SIDE_W-1:0]      o_side
);

    logic [SW+3:0] w_sh;
    logic [SW+3:0] w_trial;
    logic [SW+3:0] w_diff;
    logic          w_ge;
    logic [SW+1:0] n_rem;
    logic [SW-1:0] n_root;

    always_comb begin
        w_sh    = {i_rem, i_rad[2*SW-1 -: 2]};
        w_trial = {2'b00, i_root, 2'b01};
        w_diff  = w_sh - w_trial;
        w_ge    = (w_sh >= w_trial);
        n_rem   = w_ge ? w_diff[SW+1:0] : w_sh[SW+1:0];
        n_root  = {i_root[SW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        o_rad  <= {i_rad[2*SW-3:0], 2'b00};
        o_rem  <= n_rem;
        o_root <= n_root;
        o_side <= i_side;
    end

endmodule
`default_nettype wire

// File: rtl/qrs_div_cell.sv
// one cell of the two-lane restoring divider chain: one quotient bit per lane per cycle
`default_nettype none
module qrs_div_cell #(
    parameter int QW     = 34,
    parameter int DW     = 17,
    parameter int SIDE_W = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [1:0][DW-1:0]   i_rem,
    input  wire logic [1:0][QW-1:0]   i_work,
    input  wire logic [DW-1:0]        i_den,
    input  wire logic [SIDE_W-1:0]    i_side,
    output logic                      o_valid,
    output logic [1:0][DW-1:0]        o_rem,
    output logic [1:0][QW-1:0]        o_work,
    output logic [DW-1:0]             o_den,
    output logic [SIDE_W-1:0]         o_side
);

    logic [1:0][DW:0]   w_sh;
    logic [1:0][DW:0]   w_diff;
    logic [1:0]         w_ge;
    logic [1:0][DW-1:0] n_rem;
    logic [1:0][QW-1:0] n_work;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_sh[l]   = {i_rem[l], i_work[l][QW-1]};
            w_diff[l] = w_sh[l] - {1'b0, i_den};
            w_ge[l]   = (w_sh[l] >= {1'b0, i_den});
            n_rem[l]  = w_ge[l] ? w_diff[l][DW-1:0] : w_sh[l][DW-1:0];
            n_work[l] = {i_work[l][QW-2:0], w_ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rem  <= n_rem;
        o_work <= n_work;
        o_den  <= i_den;
        o_side <= i_side;
    end

endmodule
`default_nettype wire

// File: rtl/quadratic_root_solver_top.sv
// top level of the quadratic root solver: multiply, discriminant, sqrt chain, divider chain
// throughput: one request per cycle, busy never rises; every stage is a register or a cell
// the chain depths: 25 square root cells and 34 divider cells, between register stages 0 to 4
// reset: synchronous active low, clears the valid bits of every stage; payload is not reset
// the receiver cannot stall: each result shows for one cycle with o_strobe high
`default_nettype none
module quadratic_root_solver_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire qrs_pkg::t_req i_req,
    output logic               o_strobe,
    output qrs_pkg::t_res      o_res
);

    localparam int CW      = qrs_pkg::COEF_W;
    localparam int RW      = qrs_pkg::ROOT_W;
    localparam int FR_DIFF = qrs_pkg::ROOT_FRAC - qrs_pkg::COEF_FRAC;
    localparam int SH      = 2 * FR_DIFF;          // radicand scaling for the root fraction
    localparam int DW      = 2 * CW + 3;           // signed discriminant width
    localparam int RAD_W   = DW - 1 + SH;          // radicand width (even)
    localparam int SW      = RAD_W / 2;            // root bits, one per sqrt cell
    localparam int NW      = SW + 2 + qrs_pkg::COEF_FRAC; // signed numerator width
    localparam int QW      = NW - 1;               // numerator magnitude, one bit per div cell
    localparam int DEN_W   = CW + 1;               // magnitude of 2a
    localparam int XW      = (QW + 1 > RW) ? QW + 1 : RW + 1; // signed quotient for clipping
    localparam int SQ_SIDE = 2 * CW + 2;
    localparam int DV_SIDE = 4;

    localparam logic signed [XW-1:0] HI = {{(XW - RW + 1){1'b0}}, {(RW - 1){1'b1}}};
    localparam logic signed [XW-1:0] LO = ~HI;

    // never stalls the sender
    assign busy = 1'b0;

    // stage 0: capture the request
    logic         r0_v;
    qrs_pkg::t_req r0_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else begin
            r0_v <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_req <= i_req;
    end

    // stage 1: the two products b*b and a*c
    logic                     r1_v;
    logic signed [2*CW-1:0]   r1_bb;
    logic signed [2*CW-1:0]   r1_ac;
    logic signed [CW-1:0]     r1_a;
    logic signed [CW-1:0]     r1_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_bb <= r0_req.coef_linear * r0_req.coef_linear;
        r1_ac <= r0_req.coef_square * r0_req.coef_const;
        r1_a  <= r0_req.coef_square;
        r1_b  <= r0_req.coef_linear;
    end

    // stage 2: discriminant, case code and scaled radicand
    logic signed [DW-1:0] w_d;
    qrs_pkg::t_root_case  w_case;
    logic [RAD_W-1:0]     w_rad;

    always_comb begin
        w_d = DW'(r1_bb) - (DW'(r1_ac) <<< 2);
        priority if (r1_a == '0) begin
            w_case = qrs_pkg::CASE_DEGEN;
        end else if (w_d[DW-1]) begin
            w_case = qrs_pkg::CASE_NONE;
        end else if (w_d == '0) begin
            w_case = qrs_pkg::CASE_DOUBLE;
        end else begin
            w_case = qrs_pkg::CASE_TWO;
        end
        // negative discriminant: radicand held at zero, roots are dropped later anyway
        w_rad = w_d[DW-1] ? '0 : {w_d[DW-2:0], {SH{1'b0}}};
    end

    logic               r2_v;
    logic [RAD_W-1:0]   r2_rad;
    logic [SQ_SIDE-1:0] r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_rad  <= w_rad;
        r2_side <= {r1_a, r1_b, w_case};
    end

    // square root chain, one root bit per cell
    logic [SW:0]                sq_v;
    logic [SW:0][RAD_W-1:0]     sq_rad;
    logic [SW:0][SW+1:0]        sq_rem;
    logic [SW:0][SW-1:0]        sq_root;
    logic [SW:0][SQ_SIDE-1:0]   sq_side;

    assign sq_v[0]    = r2_v;
    assign sq_rad[0]  = r2_rad;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = r2_side;

    for (genvar g = 0; g < SW; g++) begin : g_sqrt
        qrs_sqrt_cell #(
            .SW     (SW),
            .SIDE_W (SQ_SIDE)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_v[g]),
            .i_rad   (sq_rad[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .i_side  (sq_side[g]),
            .o_valid (sq_v[g+1]),
            .o_rad   (sq_rad[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1]),
            .o_side  (sq_side[g+1])
        );
    end

    // stage 3: numerators -b*2^8 +/- sqrt, moved to the quotient scale, and |2a|
    logic signed [CW-1:0] w_a3;
    logic signed [CW-1:0] w_b3;
    logic [1:0]           w_case3;
    logic signed [NW-1:0] w_nb;
    logic signed [NW-1:0] w_s;
    logic signed [NW-1:0] w_np;
    logic signed [NW-1:0] w_nm;
    logic signed [NW-1:0] w_np_neg;
    logic signed [NW-1:0] w_nm_neg;
    logic signed [CW+1:0] w_2a;
    logic signed [CW+1:0] w_2a_neg;
    logic [QW-1:0]        w_mag_p;
    logic [QW-1:0]        w_mag_m;
    logic [DEN_W-1:0]     w_den;
    logic                 w_sp;
    logic                 w_sm;

    always_comb begin
        {w_a3, w_b3, w_case3} = sq_side[SW];
        w_nb     = -(NW'(w_b3) <<< FR_DIFF);
        w_s      = NW'({1'b0, sq_root[SW]});
        w_np     = (w_nb + w_s) <<< qrs_pkg::COEF_FRAC;
        w_nm     = (w_nb - w_s) <<< qrs_pkg::COEF_FRAC;
        w_np_neg = -w_np;
        w_nm_neg = -w_nm;
        w_mag_p  = w_np[NW-1] ? w_np_neg[QW-1:0] : w_np[QW-1:0];
        w_mag_m  = w_nm[NW-1] ? w_nm_neg[QW-1:0] : w_nm[QW-1:0];
        w_2a     = (CW+2)'(w_a3) <<< 1;
        w_2a_neg = -w_2a;
        w_den    = w_a3[CW-1] ? w_2a_neg[DEN_W-1:0] : w_2a[DEN_W-1:0];
        // quotient sign, truncation toward zero comes from dividing magnitudes
        w_sp     = w_np[NW-1] ^ w_a3[CW-1];
        w_sm     = w_nm[NW-1] ^ w_a3[CW-1];
    end

    logic               r3_v;
    logic [1:0][QW-1:0] r3_mag;
    logic [DEN_W-1:0]   r3_den;
    logic [DV_SIDE-1:0] r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= sq_v[SW];
        end
    end

    always_ff @(posedge i_clk) begin
        r3_mag  <= {w_mag_m, w_mag_p};
        r3_den  <= w_den;
        r3_side <= {w_case3, w_sp, w_sm};
    end

    // divider chain, lane 0 plus root, lane 1 minus root
    logic [QW:0]                   dv_v;
    logic [QW:0][1:0][DEN_W-1:0]   dv_rem;
    logic [QW:0][1:0][QW-1:0]      dv_work;
    logic [QW:0][DEN_W-1:0]        dv_den;
    logic [QW:0][DV_SIDE-1:0]      dv_side;

    assign dv_v[0]    = r3_v;
    assign dv_rem[0]  = '0;
    assign dv_work[0] = r3_mag;
    assign dv_den[0]  = r3_den;
    assign dv_side[0] = r3_side;

    for (genvar g = 0; g < QW; g++) begin : g_div
        qrs_div_cell #(
            .QW     (QW),
            .DW     (DEN_W),
            .SIDE_W (DV_SIDE)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv_v[g]),
            .i_rem   (dv_rem[g]),
            .i_work  (dv_work[g]),
            .i_den   (dv_den[g]),
            .i_side  (dv_side[g]),
            .o_valid (dv_v[g+1]),
            .o_rem   (dv_rem[g+1]),
            .o_work  (dv_work[g+1]),
            .o_den   (dv_den[g+1]),
            .o_side  (dv_side[g+1])
        );
    end

    // stage 4: sign, clip to the root range, zero the rootless cases
    qrs_pkg::t_root_case   w_case4;
    logic                  w_sp4;
    logic                  w_sm4;
    logic signed [XW-1:0]  w_qp;
    logic signed [XW-1:0]  w_qm;
    logic signed [RW-1:0]  w_rp;
    logic signed [RW-1:0]  w_rm;
    logic                  w_satp;
    logic                  w_satm;
    logic                  w_roots;
    qrs_pkg::t_res         n_res;

    always_comb begin
        w_case4 = qrs_pkg::t_root_case'(dv_side[QW][3:2]);
        w_sp4   = dv_side[QW][1];
        w_sm4   = dv_side[QW][0];
        w_qp    = w_sp4 ? -XW'(dv_work[QW][0]) : XW'(dv_work[QW][0]);
        w_qm    = w_sm4 ? -XW'(dv_work[QW][1]) : XW'(dv_work[QW][1]);
        w_satp  = (w_qp > HI) || (w_qp < LO);
        w_satm  = (w_qm > HI) || (w_qm < LO);
        w_rp    = (w_qp > HI) ? HI[RW-1:0] : ((w_qp < LO) ? LO[RW-1:0] : w_qp[RW-1:0]);
        w_rm    = (w_qm > HI) ? HI[RW-1:0] : ((w_qm < LO) ? LO[RW-1:0] : w_qm[RW-1:0]);
        w_roots = (w_case4 == qrs_pkg::CASE_TWO) || (w_case4 == qrs_pkg::CASE_DOUBLE);
        n_res.root_case  = w_case4;
        n_res.root_plus  = w_roots ? w_rp : '0;
        n_res.root_minus = w_roots ? w_rm : '0;
        n_res.saturated  = w_roots && (w_satp || w_satm);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= dv_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        o_res <= n_res;
    end

endmodule
`default_nettype wire
